>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/iddt_pkg.sv
// Shared types and constants of the incremental DDT checker
package iddt_pkg;

    localparam int WIDTH_BITS_DEF = 7;

    localparam int COUNT_W = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;
    localparam logic [COUNT_W-1:0] COUNT_STEP = 4'd2;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef struct packed {
        logic we;          // write value, mark valid
        logic invalidate;  // mark entry undefined
        logic clear_all;   // mark every entry undefined
    } sbox_ctl_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               stop;
    } alu_res_t;

endpackage

>>> rtl/core/iddt_sbox_store.sv
// Partial S-box: value memory plus per-entry valid flags
module iddt_sbox_store #(
    parameter int WIDTH_BITS = iddt_pkg::WIDTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  iddt_pkg::sbox_ctl_t   ctl,
    input  logic [WIDTH_BITS-1:0] wr_addr,
    input  logic [WIDTH_BITS-1:0] wr_data,
    input  logic [WIDTH_BITS-1:0] rd_addr,
    output logic [WIDTH_BITS-1:0] rd_data,
    output logic                  rd_valid
);
    import iddt_pkg::*;

    localparam int SIZE = 1 << WIDTH_BITS;

    logic [SIZE-1:0]       valid_reg;
    logic [WIDTH_BITS-1:0] mem_reg [SIZE];
    logic [WIDTH_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.invalidate)
            begin
                valid_reg[wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = valid_reg[rd_addr];

endmodule

>>> rtl/core/iddt_count_ram.sv
// Difference count memory, one write and one registered read port
module iddt_count_ram #(
    parameter int WIDTH_BITS = iddt_pkg::WIDTH_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [2*WIDTH_BITS-1:0]        wr_addr,
    input  logic [iddt_pkg::COUNT_W-1:0]   wr_data,
    input  logic [2*WIDTH_BITS-1:0]        rd_addr,
    output logic [iddt_pkg::COUNT_W-1:0]   rd_data
);
    import iddt_pkg::*;

    localparam int DEPTH = 1 << (2 * WIDTH_BITS);

    logic [COUNT_W-1:0] mem_reg [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/iddt_count_alu.sv
// Saturating +2 / -2 count update with early-stop test
module iddt_count_alu (
    input  logic                         op_add,
    input  logic [iddt_pkg::COUNT_W-1:0] count_in,
    output iddt_pkg::alu_res_t           res
);
    import iddt_pkg::*;

    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] diff;

    always_comb
    begin
        sum  = {1'b0, count_in} + {1'b0, COUNT_STEP};
        diff = (count_in >= COUNT_STEP) ? (count_in - COUNT_STEP) : '0;
        if (op_add)
        begin
            res.count = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];
            res.stop  = (res.count > COUNT_STEP);
        end
        else
        begin
            res.count = diff;
            res.stop  = (diff == COUNT_STEP);
        end
    end

endmodule

>>> rtl/core/incremental_ddt_apn_checker.sv
// Top level: request sequencer of the incremental DDT checker
//
// Usage: drive req_type, position and point_value and raise start; the item
// is taken on a clock edge where start is high and busy is low. busy stays
// high until the item is finished. The result, still_apn, is shown for one
// cycle with done high; the receiver cannot hold it off.
// Set: writes the point, then walks the nonzero even-weight differences in
// ascending order, one S-box read and one count read-modify-write through
// the shared count unit for each defined partner. The walk can end early
// on a stop from the count unit. Remove: first loads the stored value in
// S_LOADC, then the same walk. Remove of an undefined point and an unknown
// request go straight to the result. Clear: flags dropped at once, then the
// count memory is zeroed one entry a cycle. Reset: the same clearing pass
// runs with busy high and gives no result. One item is in flight at a time.
`include "assert_macros.svh"

module incremental_ddt_apn_checker #(
    parameter int WIDTH_BITS = iddt_pkg::WIDTH_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [WIDTH_BITS-1:0] position,
    input  logic [WIDTH_BITS-1:0] point_value,
    output logic                  done,
    output logic                  still_apn
);
    import iddt_pkg::*;

    localparam int AW = 2 * WIDTH_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOADC,
        S_SCAN,
        S_ADDR,
        S_RMW,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic                  is_set_reg, is_set_next;
    logic                  is_rm_reg, is_rm_next;
    logic                  clr_report_reg, clr_report_next;
    logic                  ok_reg, ok_next;
    logic                  done_reg, done_next;
    logic                  still_apn_reg, still_apn_next;
    logic [WIDTH_BITS-1:0] c_reg, c_next;
    logic [WIDTH_BITS-1:0] vc_reg, vc_next;
    logic [WIDTH_BITS-1:0] a_reg, a_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [AW-1:0]         cnt_addr_reg, cnt_addr_next;

    sbox_ctl_t             sbox_ctl;
    logic [WIDTH_BITS-1:0] look_addr;
    logic [WIDTH_BITS-1:0] sbox_wr_addr;
    logic [WIDTH_BITS-1:0] sbox_rd_data;
    logic                  look_valid;

    logic                  cnt_we;
    logic [AW-1:0]         cnt_wr_addr;
    logic [COUNT_W-1:0]    cnt_wr_data;
    logic [AW-1:0]         cnt_rd_addr;
    logic [COUNT_W-1:0]    cnt_rd_data;
    alu_res_t              alu_res;

    logic                  a_last;

    // in idle the store looks up the requested position, else the partner
    assign look_addr    = (state_reg == S_IDLE) ? position : (c_reg ^ a_reg);
    assign sbox_wr_addr = (state_reg == S_IDLE) ? position : c_reg;
    assign cnt_rd_addr  = {a_reg, vc_reg ^ sbox_rd_data};
    assign a_last       = (a_reg == '1);

    assign cnt_we      = (state_reg == S_CLEAR) || (state_reg == S_RMW);
    assign cnt_wr_addr = (state_reg == S_CLEAR) ? clr_addr_reg : cnt_addr_reg;
    assign cnt_wr_data = (state_reg == S_CLEAR) ? '0 : alu_res.count;

    iddt_sbox_store #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_sbox (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (sbox_ctl),
        .wr_addr  (sbox_wr_addr),
        .wr_data  (point_value),
        .rd_addr  (look_addr),
        .rd_data  (sbox_rd_data),
        .rd_valid (look_valid)
    );

    iddt_count_ram #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_counts (
        .clk     (clk),
        .we      (cnt_we),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    iddt_count_alu u_alu (
        .op_add   (is_set_reg),
        .count_in (cnt_rd_data),
        .res      (alu_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        is_set_next     = is_set_reg;
        is_rm_next      = is_rm_reg;
        clr_report_next = clr_report_reg;
        ok_next         = ok_reg;
        done_next       = 1'b0;
        still_apn_next  = still_apn_reg;
        c_next          = c_reg;
        vc_next         = vc_reg;
        a_next          = a_reg;
        clr_addr_next   = clr_addr_reg;
        cnt_addr_next   = cnt_addr_reg;
        sbox_ctl        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    if (clr_report_reg)
                    begin
                        clr_report_next = 1'b0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    c_next      = position;
                    vc_next     = point_value;
                    a_next      = {{(WIDTH_BITS-1){1'b0}}, 1'b1};
                    ok_next     = 1'b1;
                    is_set_next = 1'b0;
                    is_rm_next  = 1'b0;
                    unique case (req_type)
                        REQ_SET:
                        begin
                            is_set_next = 1'b1;
                            sbox_ctl.we = 1'b1;
                            state_next  = S_SCAN;
                        end
                        REQ_REMOVE:
                        begin
                            is_rm_next = 1'b1;
                            state_next = look_valid ? S_LOADC : S_FINISH;
                        end
                        REQ_CLEAR:
                        begin
                            sbox_ctl.clear_all = 1'b1;
                            clr_report_next    = 1'b1;
                            clr_addr_next      = '0;
                            state_next         = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_LOADC:
            begin
                // stored value of the point being removed
                vc_next    = sbox_rd_data;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!(^a_reg) && look_valid)
                begin
                    state_next = S_ADDR;
                end
                else if (a_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end
            S_ADDR:
            begin
                cnt_addr_next = cnt_rd_addr;
                state_next    = S_RMW;
            end
            S_RMW:
            begin
                if (alu_res.stop)
                begin
                    if (is_set_reg)
                    begin
                        ok_next = 1'b0;
                    end
                    state_next = S_FINISH;
                end
                else if (a_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    a_next     = a_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_FINISH:
            begin
                sbox_ctl.invalidate = is_rm_reg;
                done_next           = 1'b1;
                still_apn_next      = ok_reg;
                state_next          = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            is_set_reg     <= 1'b0;
            is_rm_reg      <= 1'b0;
            clr_report_reg <= 1'b0;
            ok_reg         <= 1'b1;
            done_reg       <= 1'b0;
            still_apn_reg  <= 1'b1;
            c_reg          <= '0;
            vc_reg         <= '0;
            a_reg          <= '0;
            clr_addr_reg   <= '0;
            cnt_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            is_set_reg     <= is_set_next;
            is_rm_reg      <= is_rm_next;
            clr_report_reg <= clr_report_next;
            ok_reg         <= ok_next;
            done_reg       <= done_next;
            still_apn_reg  <= still_apn_next;
            c_reg          <= c_next;
            vc_reg         <= vc_next;
            a_reg          <= a_next;
            clr_addr_reg   <= clr_addr_next;
            cnt_addr_reg   <= cnt_addr_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign still_apn = still_apn_reg;

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `ASSERT_IMPLIES(a_done_idle, done, !busy, "result shown while still busy")
    `ASSERT_IMPLIES(a_fail_on_set, done && !still_apn, is_set_reg, "failure on a non-set item")
    `ASSERT_IMPLIES(a_partner_defined, state_reg == S_ADDR, look_valid && !(^a_reg),
        "count read for an undefined partner or odd-weight difference")

endmodule
